### rtl/ppr_pkg.sv
// Shared types, constants and helper functions for the palette pixel to RGB565 core.
// No dependencies; every other file in rtl/ imports this package.
package ppr_pkg;

    // Default frame limits handed to the top-level parameters.
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Depth of the command queue between front and back, and of the output buffer.
    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_FIRST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_RAMP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd4;

    localparam logic [CFG_DATA_W-1:0] ROW_WIDTH_RST = 13'd800;
    localparam logic [CFG_DATA_W-1:0] ROW_COUNT_RST = 13'd480;

    // Pixel format codes.
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_2BPP  = 3'd1;
    localparam logic [2:0] FMT_4BPP  = 3'd2;
    localparam logic [2:0] FMT_8BPP  = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;
    localparam logic [2:0] FMT_32BPP = 3'd5;

    // Input word kinds.
    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_DATA    = 1'b1;

    // Command codes carried through the queue.
    localparam logic [1:0] CMD_PAL    = 2'd0;
    localparam logic [1:0] CMD_PACKED = 2'd1;
    localparam logic [1:0] CMD_TRUE   = 2'd2;

    // Input word layout inside s_tdata.
    localparam int IN_DATA_W = 40;

    typedef struct packed {
        logic [2:0]            pixel_format;
        logic                  red_first;
        logic                  gray_ramp;
        logic [CFG_DATA_W-1:0] row_width;
        logic [CFG_DATA_W-1:0] row_count;
    } ppr_cfg_t;

    // One queued command. For a palette write, data holds bytes 2..0 of the entry;
    // for a packed byte, data[7:0] holds the raster byte; for a truecolour pixel,
    // data holds byte 2, byte 1 (green) and byte 0 from the top down.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  idx;
        logic [23:0] data;
    } ppr_cmd_t;

    // One result word as held in the output buffer.
    typedef struct packed {
        logic [15:0] pixel;
        logic        last;
        logic        row_end;
        logic        frame_end;
    } ppr_pix_t;

    // Pack three 8-bit channels into RGB565.
    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Gray level for an index: index * (255 / (2^bpp - 1)), which is bit replication.
    function automatic logic [7:0] gray_level(input logic [7:0] idx, input logic [1:0] fmt);
        logic [7:0] lvl;
        case (fmt)
            2'd0:    lvl = {8{idx[0]}};
            2'd1:    lvl = {4{idx[1:0]}};
            2'd2:    lvl = {2{idx[3:0]}};
            default: lvl = idx;
        endcase
        gray_level = lvl;
    endfunction

endpackage

### rtl/ppr_front.sv
// Front end: accepts input words, gathers truecolour bytes and classifies words into commands.
// Depends on ppr_pkg.
module ppr_front
    import ppr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata fields from bit 0 up: data_byte[7:0], entry_index[15:8], entry_first[23:16],
    // entry_middle[31:24], entry_last[39:32]
    input  logic [IN_DATA_W-1:0] s_tdata,
    // s_tuser fields from bit 0 up: action
    input  logic                 s_tuser,
    input  logic [2:0]           pixel_format,
    input  logic                 q_full,
    output logic                 q_push,
    output ppr_cmd_t             q_cmd
);

    logic [1:0]  comp_idx_reg, comp_idx_next;
    logic [15:0] held_reg, held_next;
    logic        accept;
    logic [1:0]  ci;
    logic [7:0]  byte_in;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign byte_in  = s_tdata[7:0];

    // Classify the word and advance the truecolour gather state.
    always_comb begin
        comp_idx_next = comp_idx_reg;
        held_next     = held_reg;
        q_push        = 1'b0;
        q_cmd.cmd     = CMD_PAL;
        q_cmd.idx     = s_tdata[15:8];
        q_cmd.data    = s_tdata[39:16];
        ci            = comp_idx_reg;
        if (pixel_format == FMT_24BPP && comp_idx_reg == 2'd3) begin
            ci = 2'd0;
        end
        if (accept) begin
            if (s_tuser == ACT_PALETTE) begin
                q_push = 1'b1;
            end else if (pixel_format inside {[FMT_1BPP:FMT_8BPP]}) begin
                comp_idx_next = 2'd0;
                q_push        = 1'b1;
                q_cmd.cmd     = CMD_PACKED;
                q_cmd.data    = {16'd0, byte_in};
            end else if (pixel_format inside {FMT_24BPP, FMT_32BPP}) begin
                case (ci)
                    2'd0: begin
                        held_next     = {8'd0, byte_in};
                        comp_idx_next = 2'd1;
                    end
                    2'd1: begin
                        held_next     = {byte_in, held_reg[7:0]};
                        comp_idx_next = 2'd2;
                    end
                    2'd2: begin
                        q_push        = 1'b1;
                        q_cmd.cmd     = CMD_TRUE;
                        q_cmd.data    = {byte_in, held_reg};
                        comp_idx_next = (pixel_format == FMT_32BPP) ? 2'd3 : 2'd0;
                    end
                    default: begin
                        comp_idx_next = 2'd0;
                    end
                endcase
            end
        end
    end

    // Gather state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            comp_idx_reg <= 2'd0;
            held_reg     <= 16'd0;
        end else begin
            comp_idx_reg <= comp_idx_next;
            held_reg     <= held_next;
        end
    end

endmodule

### rtl/ppr_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on ppr_pkg for the command type and depth.
module ppr_queue
    import ppr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  ppr_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output ppr_cmd_t head,
    output logic     head_valid
);

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    ppr_cmd_t        entry_reg [CMD_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(CMD_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/ppr_back.sv
// Back end: palette memory, pixel unpacking, row/frame position and the output buffer.
// Depends on ppr_pkg.
module ppr_back
    import ppr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  ppr_cfg_t    cfg,
    input  ppr_cmd_t    head,
    input  logic        head_valid,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0 up: pixel
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    // m_tuser fields from bit 0 up: row_end, frame_end
    output logic [1:0]  m_tuser
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XW1 = XW + 1;
    localparam int YW1 = YW + 1;
    localparam int LWX = (XW1 > CFG_DATA_W) ? XW1 : CFG_DATA_W;
    localparam int LWY = (YW1 > CFG_DATA_W) ? YW1 : CFG_DATA_W;
    localparam int OPW = $clog2(OUT_DEPTH);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    // Position state.
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic [2:0]    sub_reg, sub_next;

    // Effective (clamped) frame size.
    logic [LWX-1:0] w_ext;
    logic [LWY-1:0] h_ext;
    logic [XW:0]    eff_w;
    logic [YW:0]    eff_h;

    // Issue stage.
    logic        credit_ok, is_pal, is_pix, is_true, pix_last, re, fe;
    logic [2:0]  last_sub, sh_amt;
    logic [7:0]  shifted, idx, lvl;
    logic [15:0] direct_pix;
    logic [OCW-1:0] inflight;

    // Palette memory and read stage.
    logic [23:0] palette_mem [256];
    logic [23:0] pal_rd_reg;
    logic        b_valid_reg, b_direct_reg, b_last_reg, b_re_reg, b_fe_reg;
    logic [15:0] b_pix_reg, b_pixel;

    // Output buffer.
    ppr_pix_t       obuf_reg [OUT_DEPTH];
    logic [OPW-1:0] owr_reg, ord_reg;
    logic [OCW-1:0] ocount_reg, ocount_next;
    logic           opop;

    // Clamp the configured size to 1 .. MAX.
    always_comb begin
        w_ext = LWX'(cfg.row_width);
        h_ext = LWY'(cfg.row_count);
        if (w_ext == '0) begin
            eff_w = XW1'(1);
        end else if (w_ext > LWX'(MAX_WIDTH)) begin
            eff_w = XW1'(MAX_WIDTH);
        end else begin
            eff_w = w_ext[XW:0];
        end
        if (h_ext == '0) begin
            eff_h = YW1'(1);
        end else if (h_ext > LWY'(MAX_HEIGHT)) begin
            eff_h = YW1'(MAX_HEIGHT);
        end else begin
            eff_h = h_ext[YW:0];
        end
    end

    // Issue one pixel per cycle when the output side has room for it.
    always_comb begin
        inflight  = OCW'(b_valid_reg) + ocount_reg;
        credit_ok = (inflight < OCW'(OUT_DEPTH));
        is_true   = (head.cmd == CMD_TRUE);
        is_pal    = head_valid && (head.cmd == CMD_PAL);
        is_pix    = head_valid && credit_ok && (is_true || head.cmd == CMD_PACKED);

        // Unpack the current index, most significant bits first.
        last_sub = 3'd7 >> cfg.pixel_format[1:0];
        sh_amt   = 3'(sub_reg << cfg.pixel_format[1:0]);
        shifted  = head.data[7:0] << sh_amt;
        case (cfg.pixel_format[1:0])
            2'd0:    idx = {7'd0, shifted[7]};
            2'd1:    idx = {6'd0, shifted[7:6]};
            2'd2:    idx = {4'd0, shifted[7:4]};
            default: idx = shifted;
        endcase
        lvl = gray_level(idx, cfg.pixel_format[1:0]);

        if (is_true) begin
            direct_pix = cfg.red_first
                ? pack565(head.data[7:0], head.data[15:8], head.data[23:16])
                : pack565(head.data[23:16], head.data[15:8], head.data[7:0]);
        end else begin
            direct_pix = pack565(lvl, lvl, lvl);
        end

        // Row and frame ends.
        re = (({1'b0, col_reg} + XW1'(1)) >= eff_w);
        fe = re && (({1'b0, row_reg} + YW1'(1)) >= eff_h);
        pix_last = is_true || re || (sub_reg == last_sub);

        col_next = col_reg;
        row_next = row_reg;
        sub_next = sub_reg;
        if (is_pix) begin
            if (re) begin
                col_next = '0;
                row_next = fe ? '0 : row_reg + YW'(1);
            end else begin
                col_next = col_reg + XW'(1);
            end
            if (!is_true) begin
                sub_next = pix_last ? 3'd0 : sub_reg + 3'd1;
            end
        end
        pop = is_pal || (is_pix && pix_last);
    end

    // Position registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            sub_reg <= 3'd0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            sub_reg <= sub_next;
        end
    end

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (is_pal) begin
            palette_mem[head.idx] <= head.data;
        end
        pal_rd_reg <= palette_mem[idx];
    end

    // Read stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= is_pix;
        end
        b_direct_reg <= is_true || cfg.gray_ramp;
        b_pix_reg    <= direct_pix;
        b_last_reg   <= pix_last;
        b_re_reg     <= re;
        b_fe_reg     <= fe;
    end

    assign b_pixel = b_direct_reg ? b_pix_reg
                   : cfg.red_first
                       ? pack565(pal_rd_reg[7:0], pal_rd_reg[15:8], pal_rd_reg[23:16])
                       : pack565(pal_rd_reg[23:16], pal_rd_reg[15:8], pal_rd_reg[7:0]);

    // Output buffer control.
    assign opop     = m_tvalid && m_tready;
    assign m_tvalid = (ocount_reg != '0);
    assign m_tdata  = obuf_reg[ord_reg].pixel;
    assign m_tlast  = obuf_reg[ord_reg].last;
    assign m_tuser  = {obuf_reg[ord_reg].frame_end, obuf_reg[ord_reg].row_end};

    always_comb begin
        ocount_next = ocount_reg;
        if (b_valid_reg && !opop) begin
            ocount_next = ocount_reg + OCW'(1);
        end else if (!b_valid_reg && opop) begin
            ocount_next = ocount_reg - OCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owr_reg    <= '0;
            ord_reg    <= '0;
            ocount_reg <= '0;
        end else begin
            ocount_reg <= ocount_next;
            if (b_valid_reg) begin
                owr_reg <= (owr_reg == OPW'(OUT_DEPTH - 1)) ? '0 : owr_reg + OPW'(1);
            end
            if (opop) begin
                ord_reg <= (ord_reg == OPW'(OUT_DEPTH - 1)) ? '0 : ord_reg + OPW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            obuf_reg[owr_reg] <= '{pixel: b_pixel, last: b_last_reg,
                                   row_end: b_re_reg, frame_end: b_fe_reg};
        end
    end

    // The credit check must keep the output buffer from overflowing.
    a_obuf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ocount_reg <= OCW'(OUT_DEPTH))
        else $error("output buffer overflow");

    // A frame end is always also a row end.
    a_fe_is_re: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && b_fe_reg |-> b_re_reg)
        else $error("frame end without row end");

    // A row end restarts the column.
    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        is_pix && re |=> col_reg == '0)
        else $error("column did not restart after row end");

    // A palette write never shares a cycle with a pixel issue.
    a_pal_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(is_pal && is_pix))
        else $error("palette write and pixel issue together");

endmodule

### rtl/palette_pixel_to_rgb565_core.sv
// Top level of the palette pixel to RGB565 converter: configuration registers and wiring.
// Depends on ppr_pkg, ppr_front, ppr_queue and ppr_back.
// Path: a pixel passes through the command queue, the read stage and the output buffer to m_*.
// Throughput: while the queue has room, one input word per cycle for 8bpp, truecolour and
// palette writes; packed modes emit one pixel per cycle, one per index, while the output has room.
// Reset (aresetn low, synchronous) clears position, gather state and the queues;
// palette contents are kept and are undefined until written.
module palette_pixel_to_rgb565_core
    import ppr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata fields from bit 0 up: data_byte[7:0], entry_index[15:8], entry_first[23:16],
    // entry_middle[31:24], entry_last[39:32]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0 up: action
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields from bit 0 up: pixel
    output logic [15:0]           m_tdata,
    output logic                  m_tlast,
    // m_tuser fields from bit 0 up: row_end, frame_end
    output logic [1:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ppr_cfg_t cfg_reg;
    ppr_cmd_t q_cmd, q_head;
    logic     q_push, q_full, q_pop, q_head_valid;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format <= FMT_1BPP;
            cfg_reg.red_first    <= 1'b0;
            cfg_reg.gray_ramp    <= 1'b0;
            cfg_reg.row_width    <= ROW_WIDTH_RST;
            cfg_reg.row_count    <= ROW_COUNT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_wdata[2:0];
                REG_RED_FIRST:    cfg_reg.red_first    <= cfg_wdata[0];
                REG_GRAY_RAMP:    cfg_reg.gray_ramp    <= cfg_wdata[0];
                REG_ROW_WIDTH:    cfg_reg.row_width    <= cfg_wdata;
                REG_ROW_COUNT:    cfg_reg.row_count    <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ppr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .pixel_format (cfg_reg.pixel_format),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    ppr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    ppr_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

### tb/sv/rgb565_stream_checker.sv
// Scoreboard for the palette pixel to RGB565 core: predicts every pixel word from the
// accepted input and configuration writes, and compares it with the result stream.
// Depends on ppr_pkg for port widths, register indexes and format codes.
`timescale 1ns / 1ps

module rgb565_stream_checker
    import ppr_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,
    input  logic                  m_tlast,
    input  logic [1:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    pixels_owed,
    output int                    pixels_checked,
    output int                    rows_checked,
    output int                    frames_checked
);

    typedef struct packed {
        logic [15:0] pixel;
        logic        last;
        logic        row_end;
        logic        frame_end;
    } rgb_word_t;

    // Shadow copy of the palette, raster position, truecolour gather state and registers.
    logic [23:0]     palette_mem [256];
    int unsigned     col_pos;
    int unsigned     row_pos;
    logic [1:0]      gather_step;
    logic [15:0]     gathered;
    logic [2:0]      fmt_reg;
    logic            red_first_reg;
    logic            gray_reg;
    logic [12:0]     width_reg;
    logic [12:0]     height_reg;

    rgb_word_t       owed_pixels [$];
    rgb_word_t       burst [8];
    int              burst_n;
    int              errs;
    int              n_pix;
    int              n_rows;
    int              n_frames;

    initial begin
        for (int i = 0; i < 256; i++) palette_mem[i] = '0;
        errs     = 0;
        n_pix    = 0;
        n_rows   = 0;
        n_frames = 0;
    end

    function automatic logic [15:0] to_rgb565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

    // Colour of one packed index: a gray level spread over the full byte range, or a
    // palette entry with red and blue taken from the ends that red_first selects.
    function automatic logic [15:0] shade(int unsigned idx, int unsigned bpp);
        logic [7:0]  lvl;
        logic [23:0] e;
        if (gray_reg) begin
            lvl = 8'(idx * (255 / ((1 << bpp) - 1)));
            return to_rgb565(lvl, lvl, lvl);
        end
        e = palette_mem[idx & 255];
        if (red_first_reg) return to_rgb565(e[7:0], e[15:8], e[23:16]);
        return to_rgb565(e[23:16], e[15:8], e[7:0]);
    endfunction

    // Adds one pixel to the current burst and advances the raster position, using the
    // size registers clamped to the legal range.
    task automatic place_pixel(input logic [15:0] px, output bit ends_row);
        int unsigned w;
        int unsigned h;
        bit          fe;
        w = width_reg;
        h = height_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        ends_row = (col_pos + 1 >= w);
        fe = 1'b0;
        if (ends_row) begin
            col_pos = 0;
            fe = (row_pos + 1 >= h);
            row_pos = fe ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        burst[burst_n] = '{px, 1'b0, ends_row, fe};
        burst_n++;
    endtask

    // Works out the pixels caused by one accepted input word and queues them.
    task automatic convert_word(input logic act, input logic [IN_DATA_W-1:0] w);
        logic [7:0]  raster;
        int unsigned bpp;
        int unsigned idx;
        logic [1:0]  step;
        bit          ends_row;
        logic [7:0]  r;
        logic [7:0]  b;
        burst_n = 0;
        raster  = w[7:0];
        if (act == ACT_PALETTE) begin
            palette_mem[w[15:8]] = w[39:16];
            return;
        end
        if (fmt_reg <= FMT_8BPP) begin
            // Packed indexes, most significant first; the rest of the byte is dropped
            // once a row is complete.
            bpp = 1 << fmt_reg;
            gather_step = 2'd0;
            for (int k = 0; k < 8 / bpp; k++) begin
                idx = (raster >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
                place_pixel(shade(idx, bpp), ends_row);
                if (ends_row) break;
            end
        end else if (fmt_reg <= FMT_32BPP) begin
            // Truecolour: gather two bytes, emit on the third, skip alpha in 32-bit mode.
            step = gather_step;
            if (fmt_reg == FMT_24BPP && step == 2'd3) step = 2'd0;
            case (step)
                2'd0: begin
                    gathered    = {8'h00, raster};
                    gather_step = 2'd1;
                end
                2'd1: begin
                    gathered[15:8] = raster;
                    gather_step    = 2'd2;
                end
                2'd2: begin
                    r = red_first_reg ? gathered[7:0] : raster;
                    b = red_first_reg ? raster : gathered[7:0];
                    place_pixel(to_rgb565(r, gathered[15:8], b), ends_row);
                    gather_step = (fmt_reg == FMT_32BPP) ? 2'd3 : 2'd0;
                end
                default: gather_step = 2'd0;
            endcase
        end
        for (int i = 0; i < burst_n; i++) begin
            if (i == burst_n - 1) burst[i].last = 1'b1;
            owed_pixels.push_back(burst[i]);
        end
    endtask

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_PIXEL_FORMAT: fmt_reg       = val[2:0];
            REG_RED_FIRST:    red_first_reg = val[0];
            REG_GRAY_RAMP:    gray_reg      = val[0];
            REG_ROW_WIDTH:    width_reg     = val;
            REG_ROW_COUNT:    height_reg    = val;
            default: ;
        endcase
    endtask

    // Compares one delivered pixel word with the oldest prediction, field by field.
    task automatic check_pixel();
        rgb_word_t want;
        rgb_word_t got;
        got = '{m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
        if (owed_pixels.size() == 0) begin
            errs++;
            $display("%0t: pixel word %h arrived with nothing expected", $time, m_tdata);
            return;
        end
        want = owed_pixels.pop_front();
        n_pix++;
        if (want.row_end) n_rows++;
        if (want.frame_end) n_frames++;
        if (got.pixel !== want.pixel) begin
            errs++;
            $display("%0t: pixel expected %h, actual %h", $time, want.pixel, got.pixel);
        end
        if (got.last !== want.last) begin
            errs++;
            $display("%0t: last expected %b, actual %b", $time, want.last, got.last);
        end
        if (got.row_end !== want.row_end) begin
            errs++;
            $display("%0t: row_end expected %b, actual %b", $time, want.row_end,
                     got.row_end);
        end
        if (got.frame_end !== want.frame_end) begin
            errs++;
            $display("%0t: frame_end expected %b, actual %b", $time, want.frame_end,
                     got.frame_end);
        end
    endtask

    // Everything is sampled at the clock edge, so the values seen are those before it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            col_pos       = 0;
            row_pos       = 0;
            gather_step   = 2'd0;
            gathered      = '0;
            fmt_reg       = FMT_1BPP;
            red_first_reg = 1'b0;
            gray_reg      = 1'b0;
            width_reg     = ROW_WIDTH_RST;
            height_reg    = ROW_COUNT_RST;
            owed_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) check_pixel();
            if (cfg_we) apply_setting(cfg_index, cfg_wdata);
            if (s_tvalid && s_tready) convert_word(s_tuser, s_tdata);
        end
        mismatch_count <= errs;
        pixels_owed    <= owed_pixels.size();
        pixels_checked <= n_pix;
        rows_checked   <= n_rows;
        frames_checked <= n_frames;
    end

endmodule

### tb/sv/palette_pixel_to_rgb565_core_test.sv
// Top of the testbench for palette_pixel_to_rgb565_core: clock, reset, stimulus, stalls
// on the result side and the verdict. Depends on ppr_pkg and rgb565_stream_checker.
`timescale 1ns / 1ps

module palette_pixel_to_rgb565_core_test;
    import ppr_pkg::*;

    localparam logic [2:0] FMT_UNUSED_6 = 3'd6;
    localparam logic [2:0] FMT_UNUSED_7 = 3'd7;
    localparam int         HOLD_CYCLES  = 80;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [15:0]           m_tdata;
    logic                  m_tlast;
    logic [1:0]            m_tuser;

    int mismatch_count;
    int pixels_owed;
    int pixels_checked;
    int rows_checked;
    int frames_checked;

    int burst_left     = 0;
    int hold_ticket    = 0;
    int words_sent     = 0;
    int entries_sent   = 0;
    int settings_used  = 0;

    // Current format and gray flag, and which palette entries hold a known value.
    logic [2:0] cur_fmt  = FMT_1BPP;
    logic       cur_gray = 1'b0;
    bit         pal_loaded [256];

    palette_pixel_to_rgb565_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rgb565_stream_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pixels_owed    (pixels_owed),
        .pixels_checked (pixels_checked),
        .rows_checked   (rows_checked),
        .frames_checked (frames_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: segments of differing stall patterns, plus a long hold-off whenever
    // the stimulus asks for one.
    initial begin
        int seg_len;
        int seg_mode;
        int served;
        served = 0;
        forever begin
            seg_len  = $urandom_range(40, 4);
            seg_mode = $urandom_range(3, 0);
            repeat (seg_len) begin
                if (hold_ticket != served) begin
                    served = hold_ticket;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                case (seg_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(3, 0) != 0);
                    2:       m_tready <= ~m_tready;
                    default: m_tready <= ($urandom_range(2, 0) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Offers one word, in bursts of random length separated by random gaps, and
    // returns just after the edge at which it was taken.
    task automatic offer(input logic act, input logic [IN_DATA_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
            burst_left = $urandom_range(24, 1);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Raster byte; the palette fields are filled with noise. In the indexed palette
    // modes any entry the byte refers to is loaded first if it has never been written.
    task automatic send_byte(input logic [7:0] raster);
        int unsigned bpp;
        int unsigned idx;
        if (cur_fmt <= FMT_8BPP && !cur_gray) begin
            bpp = 1 << cur_fmt;
            for (int k = 0; k < 8 / bpp; k++) begin
                idx = (raster >> (8 - bpp * (k + 1))) & ((1 << bpp) - 1);
                if (!pal_loaded[idx])
                    send_entry(8'(idx), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        offer(ACT_DATA, {$urandom(), raster});
    endtask

    task automatic send_entry(input logic [7:0] idx, input logic [7:0] e0,
                              input logic [7:0] e1, input logic [7:0] e2);
        offer(ACT_PALETTE, {e2, e1, e0, idx, 8'($urandom)});
        pal_loaded[idx] = 1'b1;
        entries_sent++;
    endtask

    // Stops offering and waits until every predicted pixel has come out, then allows
    // for words still inside the block that produce nothing.
    task automatic quiesce();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pixels_owed != 0);
        repeat (12) @(posedge aclk);
    endtask

    // Writes all five registers back to back once the block is idle.
    task automatic configure(input logic [2:0] fmt, input logic rf, input logic gr,
                             input int w, input int h);
        quiesce();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PIXEL_FORMAT;
        cfg_wdata <= CFG_DATA_W'(fmt);
        @(posedge aclk);
        cfg_index <= REG_RED_FIRST;
        cfg_wdata <= CFG_DATA_W'(rf);
        @(posedge aclk);
        cfg_index <= REG_GRAY_RAMP;
        cfg_wdata <= CFG_DATA_W'(gr);
        @(posedge aclk);
        cfg_index <= REG_ROW_WIDTH;
        cfg_wdata <= CFG_DATA_W'(w);
        @(posedge aclk);
        cfg_index <= REG_ROW_COUNT;
        cfg_wdata <= CFG_DATA_W'(h);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_fmt   = fmt;
        cur_gray  = gr;
        settings_used++;
    endtask

    initial begin
        int         phase;
        int         n;
        int         len;
        int         random_count;
        logic [2:0] fmt;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Black and white entries to start with; the others are loaded when a raster
        // byte first needs them, so no lookup ever hits an unwritten entry.
        send_entry(8'h00, 8'h00, 8'h00, 8'h00);
        send_entry(8'hff, 8'hff, 8'hff, 8'hff);

        // 1bpp with leftover bits dropped at row end, and a frame that wraps.
        configure(FMT_1BPP, 1'b0, 1'b0, 5, 2);
        send_byte(8'hff);
        send_byte(8'h00);
        // 2bpp gray ramp, red first, one-row frame.
        configure(FMT_2BPP, 1'b1, 1'b1, 3, 1);
        send_byte(8'he4);
        // 4bpp with a zero width and an oversized height, both clamped.
        configure(FMT_4BPP, 1'b0, 1'b0, 0, 8191);
        send_byte(8'h5a);
        // 8bpp palette with an oversized width, zero height, and an entry rewritten.
        configure(FMT_8BPP, 1'b1, 1'b0, 8191, 0);
        send_byte(8'h00);
        send_byte(8'hff);
        send_entry(8'hff, 8'hf8, 8'h04, 8'h07);
        send_byte(8'hff);
        // Width shrunk below the current column: the next pixel ends the row.
        configure(FMT_8BPP, 1'b0, 1'b1, 2, 3);
        send_byte(8'h80);
        send_byte(8'h7f);
        // 24bpp: one whole pixel, then a pixel left two bytes in.
        configure(FMT_24BPP, 1'b0, 1'b0, 2, 1);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'hab);
        send_byte(8'hcd);
        // 32bpp completes that pixel and waits for alpha; 24bpp then starts afresh.
        configure(FMT_32BPP, 1'b1, 1'b0, 2, 1);
        send_byte(8'hef);
        configure(FMT_24BPP, 1'b1, 1'b0, 2, 1);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h03);
        // Unused format codes ignore raster bytes.
        configure(FMT_UNUSED_6, 1'b0, 1'b0, 4, 2);
        send_byte(8'h55);
        configure(FMT_UNUSED_7, 1'b1, 1'b1, 4, 2);
        send_byte(8'haa);
        // A packed byte in the middle of a truecolour pixel discards the gathered bytes.
        configure(FMT_24BPP, 1'b0, 1'b0, 4, 2);
        send_byte(8'h99);
        configure(FMT_1BPP, 1'b0, 1'b1, 4, 2);
        send_byte(8'h0f);
        configure(FMT_32BPP, 1'b0, 1'b0, 4, 2);
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(8'h80);

        // Random phases; the first one holds the result side off to fill the block.
        random_count = 0;
        phase = 0;
        while (random_count < 110) begin
            if (phase == 0) begin
                fmt = FMT_1BPP;
                configure(fmt, 1'b0, 1'b0, 64, 4);
                hold_ticket <= hold_ticket + 1;
                n = 24;
            end else begin
                if ($urandom_range(11, 0) == 0)
                    fmt = ($urandom_range(1, 0) == 0) ? FMT_UNUSED_6 : FMT_UNUSED_7;
                else
                    fmt = 3'($urandom_range(FMT_32BPP, FMT_1BPP));
                if ($urandom_range(7, 0) == 0)
                    configure(fmt, 1'($urandom), 1'($urandom), $urandom_range(8191, 1000),
                              $urandom_range(8191, 0));
                else
                    configure(fmt, 1'($urandom), 1'($urandom), $urandom_range(9, 0),
                              $urandom_range(4, 0));
                n = (fmt > FMT_32BPP) ? $urandom_range(4, 2) : $urandom_range(30, 12);
            end
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9, 0) == 0) begin
                    send_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                    random_count++;
                end else if (fmt == FMT_24BPP || fmt == FMT_32BPP) begin
                    // Mostly whole pixels, now and then a broken one.
                    len = (fmt == FMT_24BPP) ? 3 : 4;
                    if ($urandom_range(5, 0) == 0) len = $urandom_range(len - 1, 1);
                    repeat (len) send_byte(8'($urandom));
                    random_count += len;
                end else begin
                    send_byte(8'($urandom));
                    if (fmt <= FMT_8BPP) random_count++;
                end
            end
            phase++;
        end

        quiesce();
        if (pixels_owed != 0)
            $display("%0d expected pixel words never arrived", pixels_owed);
        $display("Covered %0d input words (%0d palette writes) over %0d register settings,",
                 words_sent, entries_sent, settings_used);
        $display("all packed and truecolour formats: %0d pixels, %0d row ends, %0d frame ends.",
                 pixels_checked, rows_checked, frames_checked);
        if (mismatch_count == 0 && pixels_owed == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### palette_pixel_to_rgb565_core.f
rtl/ppr_pkg.sv
rtl/ppr_front.sv
rtl/ppr_queue.sv
rtl/ppr_back.sv
rtl/palette_pixel_to_rgb565_core.sv
tb/sv/rgb565_stream_checker.sv
tb/sv/palette_pixel_to_rgb565_core_test.sv
